/* hw/rtl/assert_macros.svh */
// Assertion macros used by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form: antecedent |-> consequent under the same clock and reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  `ASSERT_CLKD(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

/* hw/rtl/aluf_pkg.sv */
// Package: operation codes, width constants and flag bundle for the ALU flag unit.
package aluf_pkg;

  localparam int unsigned DataW = 16;

  // Operation codes; bit 0 selects byte width
  typedef enum logic [3:0] {
    OP_ADDW  = 4'd0,
    OP_ADDB  = 4'd1,
    OP_ADCW  = 4'd2,
    OP_ADCB  = 4'd3,
    OP_INCW  = 4'd4,
    OP_INCB  = 4'd5,
    OP_SUBW  = 4'd6,
    OP_SUBB  = 4'd7,
    OP_SBBW  = 4'd8,
    OP_SBBB  = 4'd9,
    OP_DECW  = 4'd10,
    OP_DECB  = 4'd11,
    OP_TESTW = 4'd12,
    OP_TESTB = 4'd13
  } aluf_op_e;

  localparam logic [DataW-1:0] MaskWord = 16'hFFFF;
  localparam logic [DataW-1:0] MaskByte = 16'h00FF;
  localparam logic [DataW-1:0] MsbWord  = 16'h8000;
  localparam logic [DataW-1:0] MsbByte  = 16'h0080;

  // Flag bundle handed from the compute stage to the result register
  typedef struct packed {
    logic sign;
    logic zero;
    logic overflow;
    logic carry;
    logic invalid;
  } aluf_flags_t;

endpackage

/* hw/rtl/x86_16bit_alu_flag_unit.sv */
// Top level: 8086-style condition flag unit with input and result registers.
//
// Usage:
//   Command channel: an operation beat (req_type_i, operand_a_i, operand_b_i,
//   carry_in_i) is taken at each rising edge where start_i is high and busy_o
//   is low. busy_o is always low, so a new beat may be issued every cycle.
//   Result channel: done_o is high for exactly one cycle and the flag outputs
//   (sign, zero, overflow, carry, invalid_op) are valid in that cycle only.
//   A taken beat passes the operand register and then the flag register, so
//   it is registered twice before done_o rises for it. Throughput: one beat
//   per cycle, through the 17-bit add/subtract path between the two
//   registers.
//   Reset: rst_ni low clears the valid pipeline; no result is shown until a
//   new beat is issued. Results are never held back: the receiver cannot
//   stall and must take each beat in the cycle done_o is high.
//   Unknown operation codes set invalid_op_o with all other flags low.
//
`include "assert_macros.svh"

module x86_16bit_alu_flag_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  req_type_i,
  input  logic [15:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  input  logic        carry_in_i,
  output logic        done_o,
  output logic        sign_flag_o,
  output logic        zero_flag_o,
  output logic        overflow_flag_o,
  output logic        carry_flag_o,
  output logic        invalid_op_o
);

  logic                         in_vld_q;
  logic [3:0]                   op_q;
  logic [aluf_pkg::DataW-1:0]   a_q;
  logic [aluf_pkg::DataW-1:0]   b_q;
  logic                         ci_q;
  aluf_pkg::aluf_flags_t        flags_d;
  aluf_pkg::aluf_flags_t        flags_q;
  logic                         done_q;

  // Never stalls
  assign busy_o = 1'b0;

  // Input valid and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= start_i;
      done_q   <= in_vld_q;
    end
  end

  // Operand register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q <= req_type_i;
      a_q  <= operand_a_i;
      b_q  <= operand_b_i;
      ci_q <= carry_in_i;
    end
  end

  aluf_flags u_flags (
    .op_i    (op_q),
    .a_i     (a_q),
    .b_i     (b_q),
    .ci_i    (ci_q),
    .flags_o (flags_d)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      flags_q <= flags_d;
    end
  end

  assign done_o          = done_q;
  assign sign_flag_o     = flags_q.sign;
  assign zero_flag_o     = flags_q.zero;
  assign overflow_flag_o = flags_q.overflow;
  assign carry_flag_o    = flags_q.carry;
  assign invalid_op_o    = flags_q.invalid;

  // Checks
  `ASSERT_CLKD(a_start_done, clk_i, rst_ni, start_i |-> ##2 done_o, "accepted beat lost")
  `ASSERT_CLKD(a_no_ghost, clk_i, rst_ni, !in_vld_q |=> !done_o, "result without a beat")
  `ASSERT_IMPL(a_invalid_clean, clk_i, rst_ni, done_o && invalid_op_o,
               !sign_flag_o && !zero_flag_o && !overflow_flag_o && !carry_flag_o,
               "flags set on invalid op")
  `ASSERT_IMPL(a_zero_sign, clk_i, rst_ni, done_o && zero_flag_o, !sign_flag_o,
               "zero result with sign set")

endmodule

/* hw/rtl/aluf_flags.sv */
// Combinational flag computation for one registered ALU operation.
module aluf_flags (
  input  logic [3:0]                     op_i,
  input  logic [aluf_pkg::DataW-1:0]     a_i,
  input  logic [aluf_pkg::DataW-1:0]     b_i,
  input  logic                           ci_i,
  output aluf_pkg::aluf_flags_t          flags_o
);

  logic                        byte_op;
  logic [aluf_pkg::DataW-1:0]  mask;
  logic [aluf_pkg::DataW-1:0]  msb;
  logic [aluf_pkg::DataW-1:0]  a_m;
  logic [aluf_pkg::DataW-1:0]  b_m;
  logic [aluf_pkg::DataW:0]    sum;
  logic [aluf_pkg::DataW:0]    diff;
  logic                        use_ci;
  logic [aluf_pkg::DataW-1:0]  res;
  logic                        ovf;
  logic                        cy;
  logic                        bad;

  // Width selection from the low opcode bit
  assign byte_op = op_i[0];
  assign mask    = byte_op ? aluf_pkg::MaskByte : aluf_pkg::MaskWord;
  assign msb     = byte_op ? aluf_pkg::MsbByte  : aluf_pkg::MsbWord;
  assign a_m     = a_i & mask;
  assign b_m     = b_i & mask;

  // Carry is folded in only for adc and sbb
  assign use_ci = ci_i & ((op_i == aluf_pkg::OP_ADCW) || (op_i == aluf_pkg::OP_ADCB) ||
                          (op_i == aluf_pkg::OP_SBBW) || (op_i == aluf_pkg::OP_SBBB));

  // Shared adder and subtractor, one bit wider for carry/borrow out
  assign sum  = {1'b0, a_m} + {1'b0, b_m} + {{aluf_pkg::DataW{1'b0}}, use_ci};
  assign diff = {1'b0, a_m} - {1'b0, b_m} - {{aluf_pkg::DataW{1'b0}}, use_ci};

  // Per-operation result, overflow and carry
  always_comb begin
    res = '0;
    ovf = 1'b0;
    cy  = 1'b0;
    bad = 1'b0;
    case (op_i)
      aluf_pkg::OP_ADDW, aluf_pkg::OP_ADDB, aluf_pkg::OP_ADCW, aluf_pkg::OP_ADCB: begin
        res = sum[aluf_pkg::DataW-1:0] & mask;
        ovf = |(~(a_m ^ b_m) & (a_m ^ res) & msb);
        cy  = byte_op ? sum[8] : sum[aluf_pkg::DataW];
      end
      aluf_pkg::OP_INCW, aluf_pkg::OP_INCB: begin
        res = (a_m + 16'd1) & mask;
        ovf = (a_m == (msb - 16'd1));
        cy  = ci_i;
      end
      aluf_pkg::OP_SUBW, aluf_pkg::OP_SUBB, aluf_pkg::OP_SBBW, aluf_pkg::OP_SBBB: begin
        res = diff[aluf_pkg::DataW-1:0] & mask;
        ovf = |((a_m ^ b_m) & (a_m ^ res) & msb);
        // negative difference shows in the top bit for both widths
        cy  = diff[aluf_pkg::DataW];
      end
      aluf_pkg::OP_DECW, aluf_pkg::OP_DECB: begin
        res = (a_m - 16'd1) & mask;
        ovf = (a_m == msb);
        cy  = ci_i;
      end
      aluf_pkg::OP_TESTW, aluf_pkg::OP_TESTB: begin
        res = a_m;
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  // Flag packing; unknown codes report only the error flag
  always_comb begin
    flags_o.sign     = !bad && (|(res & msb));
    flags_o.zero     = !bad && (res == '0);
    flags_o.overflow = !bad && ovf;
    flags_o.carry    = !bad && cy;
    flags_o.invalid  = bad;
  end

endmodule
